FILE: rtl/ict_pkg.sv
// Shared types and constants of the interval coverage tracker.
// No dependencies; every other file imports it.
package ict_pkg;

  localparam int FIELD_W = 48;
  localparam int MODE_W  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_GAPS  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    C_HOLD,
    C_INSERT,
    C_MERGE,
    C_ABSORB
  } cell_op_e;

  typedef struct packed {
    logic               hit;
    logic               table_full;
    logic               gap_valid;
    logic [FIELD_W-1:0] gap_start;
    logic [FIELD_W-1:0] gap_end;
    logic               last;
  } rsp_t;

endpackage

FILE: rtl/ict_intf.sv
// Valid/ready channels of the interval coverage tracker: request and result.
// Depends on ict_pkg.
interface ict_req_if import ict_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [FIELD_W-1:0] range_start;
  logic [FIELD_W-1:0] range_end;

  modport source (output valid, mode, range_start, range_end, input ready);
  modport sink   (input valid, mode, range_start, range_end, output ready);
endinterface

interface ict_rsp_if import ict_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               table_full;
  logic               gap_valid;
  logic [FIELD_W-1:0] gap_start;
  logic [FIELD_W-1:0] gap_end;
  logic               last;

  modport source (output valid, hit, table_full, gap_valid, gap_start, gap_end, last,
                  input ready);
  modport sink   (input valid, hit, table_full, gap_valid, gap_start, gap_end, last,
                  output ready);
endinterface

FILE: rtl/ict_cell.sv
// One table cell: holds one covered range, compares it against the broadcast key
// and shifts to or from its neighbors. Depends on ict_pkg.
module ict_cell import ict_pkg::*; #(
  parameter int OW  = 48,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  cell_op_e      op_i,
  input  logic [CW-1:0] ptr_i,
  input  logic [OW-1:0] key_lo_i,
  input  logic [OW-1:0] key_hi_i,
  input  logic [OW-1:0] lft_lo_i,
  input  logic [OW-1:0] lft_hi_i,
  input  logic [OW-1:0] rgt_lo_i,
  input  logic [OW-1:0] rgt_hi_i,
  output logic [OW-1:0] lo_o,
  output logic [OW-1:0] hi_o,
  output logic          touch_o,
  output logic          gt_o,
  output logic          ntouch_o
);

  logic [OW-1:0] lo_q, hi_q;
  logic          at_ptr, past_ptr;

  assign at_ptr   = (CW'(IDX) == ptr_i);
  assign past_ptr = (CW'(IDX) > ptr_i);

  assign lo_o     = lo_q;
  assign hi_o     = hi_q;
  assign touch_o  = (lo_q <= key_hi_i) && (key_lo_i <= hi_q);
  assign gt_o     = (lo_q > key_hi_i);
  assign ntouch_o = (lo_q <= rgt_hi_i) && (rgt_lo_i <= hi_q);

  always_ff @(posedge clk_i) begin
    case (op_i)
      C_INSERT: begin
        if (at_ptr) begin
          lo_q <= key_lo_i;
          hi_q <= key_hi_i;
        end else if (past_ptr) begin
          lo_q <= lft_lo_i;
          hi_q <= lft_hi_i;
        end
      end
      C_MERGE: begin
        if (at_ptr) begin
          lo_q <= (key_lo_i < lo_q) ? key_lo_i : lo_q;
          hi_q <= (key_hi_i > hi_q) ? key_hi_i : hi_q;
        end
      end
      C_ABSORB: begin
        if (at_ptr) begin
          lo_q <= (rgt_lo_i < lo_q) ? rgt_lo_i : lo_q;
          hi_q <= (rgt_hi_i > hi_q) ? rgt_hi_i : hi_q;
        end else if (past_ptr) begin
          lo_q <= rgt_lo_i;
          hi_q <= rgt_hi_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/interval_coverage_tracker.sv
// Interval coverage tracker top level: sequencer over a row of ict_cell.
// Depends on ict_pkg, ict_intf and ict_cell.
//
// Usage: requests arrive as words on req_i (mode, range_start, range_end) and
// are taken when valid and ready are both high; ready is high only while the
// sequencer is idle, so one request is in work at a time. Results leave as
// words on rsp_o through one output register; the final word of each request
// has last set. Add, query and clear give one word; gaps gives one word per
// uncovered subrange, or one empty word.
// The user must write the file length through cfg_we_i / cfg_wdata_i only while the
// block is idle; the block itself does not enforce this. Add and query scan the table
// one entry per cycle; a merge then absorbs each following entry that touches the
// merged range. Gaps makes two table scans for each subrange found.
// A single scan pointer over the cells drives all scans.
// Reset empties the table and clears the file length; no clearing pass is needed.
// While the receiver stalls, one finished word waits in the output register and
// the sequencer holds at its next result until that word is taken.
module interval_coverage_tracker import ict_pkg::*; #(
  parameter int MAX_RANGES  = 16,
  parameter int OFFSET_BITS = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  ict_req_if.sink            req_i,
  ict_rsp_if.source          rsp_o
);

  localparam int OW = OFFSET_BITS;
  localparam int N  = MAX_RANGES;
  localparam int CW = $clog2(N + 1);
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int NW = $clog2(N + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_W, S_ADD_S, S_ABS, S_QRY_W, S_QRY_S,
    S_G_TOP, S_G_TW, S_G_TS, S_G_NW, S_G_NS, S_G_FIN, S_RESP
  } state_e;

  state_e        st_q, ret_q;
  logic [CW-1:0] cnt_q, ptr_q;
  logic [NW-1:0] n_q;
  logic [OW-1:0] fs_q, klo_q, khi_q, p_q, e_q, gs_q, pgs_q, pge_q;
  logic          pend_q, ov_q;
  rsp_t          r_q, o_q;
  logic [N-1:0]  tv_q, gv_q;

  logic [OW-1:0] ent_lo [N];
  logic [OW-1:0] ent_hi [N];
  logic [N-1:0]  tv, gv, ntv;
  cell_op_e      cop;

  logic [OW-1:0] rs, re, rcl;
  logic [IW-1:0] ri;
  logic          pv, tb, gb, nt, full;
  logic [OW-1:0] est, een, nf_ge, ng_e;
  logic          ng_stop;
  state_e        ng_nxt;
  logic          rsp_load;

  assign rs  = OW'(req_i.range_start);
  assign re  = OW'(req_i.range_end);
  assign rcl = (re > fs_q) ? fs_q : re;

  assign ri   = ptr_q[IW-1:0];
  assign pv   = (ptr_q < cnt_q);
  assign tb   = pv && tv_q[ri];
  assign gb   = pv && gv_q[ri];
  assign est  = ent_lo[ri];
  assign een  = ent_hi[ri];
  assign nt   = ntv[ri] && ((CW + 1)'(ptr_q) + 1'b1 < (CW + 1)'(cnt_q));
  assign full = (cnt_q == CW'(N));

  assign nf_ge   = gb ? est : fs_q;
  assign ng_e    = (nf_ge > e_q) ? e_q : nf_ge;
  assign ng_stop = (nf_ge > e_q) || (n_q == NW'(N));
  assign ng_nxt  = ng_stop ? S_G_FIN : S_G_TOP;

  assign rsp_load = (st_q == S_RESP) && (!ov_q || rsp_o.ready);

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [OW-1:0] l_lo, l_hi, r_lo, r_hi;
    if (i == 0) begin : g_first
      assign l_lo = '0;
      assign l_hi = '0;
    end else begin : g_mid_l
      assign l_lo = ent_lo[i-1];
      assign l_hi = ent_hi[i-1];
    end
    if (i == N - 1) begin : g_last
      assign r_lo = '0;
      assign r_hi = '0;
    end else begin : g_mid_r
      assign r_lo = ent_lo[i+1];
      assign r_hi = ent_hi[i+1];
    end

    ict_cell #(.OW(OW), .CW(CW), .IDX(i)) u_cell (
      .clk_i    (clk_i),
      .op_i     (cop),
      .ptr_i    (ptr_q),
      .key_lo_i (klo_q),
      .key_hi_i (khi_q),
      .lft_lo_i (l_lo),
      .lft_hi_i (l_hi),
      .rgt_lo_i (r_lo),
      .rgt_hi_i (r_hi),
      .lo_o     (ent_lo[i]),
      .hi_o     (ent_hi[i]),
      .touch_o  (tv[i]),
      .gt_o     (gv[i]),
      .ntouch_o (ntv[i])
    );
  end

  always_comb begin
    cop = C_HOLD;
    case (st_q)
      S_ADD_S: begin
        if (tb) begin
          cop = C_MERGE;
        end else if ((!pv || gb) && !full) begin
          cop = C_INSERT;
        end
      end
      S_ABS: begin
        if (nt) begin
          cop = C_ABSORB;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    tv_q <= tv;
    gv_q <= gv;
  end

  assign req_i.ready      = (st_q == S_IDLE);
  assign rsp_o.valid      = ov_q;
  assign rsp_o.hit        = o_q.hit;
  assign rsp_o.table_full = o_q.table_full;
  assign rsp_o.gap_valid  = o_q.gap_valid;
  assign rsp_o.gap_start  = o_q.gap_start;
  assign rsp_o.gap_end    = o_q.gap_end;
  assign rsp_o.last       = o_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ret_q  <= S_IDLE;
      cnt_q  <= '0;
      ptr_q  <= '0;
      n_q    <= '0;
      fs_q   <= '0;
      klo_q  <= '0;
      khi_q  <= '0;
      p_q    <= '0;
      e_q    <= '0;
      gs_q   <= '0;
      pgs_q  <= '0;
      pge_q  <= '0;
      pend_q <= 1'b0;
      ov_q   <= 1'b0;
      r_q    <= '0;
      o_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        fs_q <= OW'(cfg_wdata_i);
      end
      if (rsp_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
      case (st_q)
        S_IDLE: begin
          if (req_i.valid) begin
            ptr_q <= '0;
            ret_q <= S_IDLE;
            case (mode_e'(req_i.mode))
              MODE_ADD: begin
                r_q   <= '0;
                klo_q <= rs;
                khi_q <= rcl;
                st_q  <= S_ADD_W;
              end
              MODE_QUERY: begin
                r_q   <= '0;
                klo_q <= rs;
                khi_q <= re;
                st_q  <= S_QRY_W;
              end
              MODE_GAPS: begin
                r_q    <= '0;
                p_q    <= rs;
                e_q    <= rcl;
                n_q    <= '0;
                pend_q <= 1'b0;
                st_q   <= S_G_TOP;
              end
              default: begin
                cnt_q      <= '0;
                r_q        <= '{last: 1'b1, default: '0};
                st_q       <= S_RESP;
              end
            endcase
          end
        end
        S_ADD_W: st_q <= S_ADD_S;
        S_ADD_S: begin
          if (tb) begin
            st_q <= S_ABS;
          end else if (!pv || gb) begin
            if (full) begin
              r_q.table_full <= 1'b1;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
            r_q.last <= 1'b1;
            st_q     <= S_RESP;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_ABS: begin
          if (nt) begin
            cnt_q <= cnt_q - 1'b1;
          end else begin
            r_q.last <= 1'b1;
            st_q     <= S_RESP;
          end
        end
        S_QRY_W: st_q <= S_QRY_S;
        S_QRY_S: begin
          if (!pv || tb) begin
            r_q.hit  <= tb;
            r_q.last <= 1'b1;
            st_q     <= S_RESP;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_G_TOP: begin
          if (p_q >= fs_q) begin
            st_q <= S_G_FIN;
          end else begin
            klo_q <= p_q;
            khi_q <= p_q;
            ptr_q <= '0;
            st_q  <= S_G_TW;
          end
        end
        S_G_TW: st_q <= S_G_TS;
        S_G_TS: begin
          if (tb && (een == fs_q)) begin
            st_q <= S_G_FIN;
          end else if (!pv || tb) begin
            gs_q  <= tb ? een : p_q;
            khi_q <= tb ? een : p_q;
            ptr_q <= '0;
            st_q  <= S_G_NW;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_G_NW: st_q <= S_G_NS;
        S_G_NS: begin
          if (!pv || gb) begin
            if (gs_q >= e_q) begin
              st_q <= S_G_FIN;
            end else begin
              n_q    <= n_q + 1'b1;
              p_q    <= nf_ge;
              pend_q <= 1'b1;
              pgs_q  <= gs_q;
              pge_q  <= ng_e;
              if (pend_q) begin
                r_q.gap_valid <= 1'b1;
                r_q.gap_start <= FIELD_W'(pgs_q);
                r_q.gap_end   <= FIELD_W'(pge_q);
                r_q.last      <= 1'b0;
                ret_q         <= ng_nxt;
                st_q          <= S_RESP;
              end else begin
                st_q <= ng_nxt;
              end
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_G_FIN: begin
          r_q.gap_valid <= pend_q;
          r_q.gap_start <= pend_q ? FIELD_W'(pgs_q) : '0;
          r_q.gap_end   <= pend_q ? FIELD_W'(pge_q) : '0;
          r_q.last      <= 1'b1;
          ret_q         <= S_IDLE;
          st_q          <= S_RESP;
        end
        S_RESP: begin
          if (rsp_load) begin
            o_q  <= r_q;
            st_q <= ret_q;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N))
    else $error("entry count above table depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= cnt_q)
    else $error("scan pointer past entry count");

  a_absorb_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_ABS && nt) |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("absorb did not drop an entry");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.gap_valid) |-> rsp_o.last)
    else $error("word without gap not marked last");

  a_full_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_ADD_S && !tb && (!pv || gb) && full) |=> r_q.table_full)
    else $error("full table not flagged");

endmodule
